### rtl/core/input_event_fifo_with_key_translation_defines.svh
// Assertion macros for the input event ring.
`ifndef INPUT_EVENT_FIFO_WITH_KEY_TRANSLATION_DEFINES_SVH
`define INPUT_EVENT_FIFO_WITH_KEY_TRANSLATION_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define IEVF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ievf check failed");

// Next-cycle implication, off while reset is high.
`define IEVF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ievf check failed");

`endif

### rtl/core/ievf_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and the scan-code translation for the input event ring.
package ievf_pkg;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_PEEK  = 2'd2,
    ACT_FLUSH = 2'd3
  } act_t;

  typedef enum logic {
    ST_IDLE,
    ST_FINISH
  } state_t;

  localparam logic [2:0] KIND_NONE     = 3'd0;
  localparam logic [2:0] KIND_KEY_DOWN = 3'd1;
  localparam logic [2:0] KIND_KEY_UP   = 3'd2;

  localparam int         CFG_IDX_W  = 1;
  localparam logic [0:0] CFG_ENABLE = 1'b0;
  localparam logic [0:0] CFG_ASCII  = 1'b1;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] x;
    logic [15:0] y;
    logic [2:0]  mods;
  } slot_t;

  typedef struct packed {
    logic take;
    logic load;
  } ievf_cmd_t;

  typedef struct packed {
    logic out_free;
  } ievf_sts_t;

  // Low byte of the set-1 scan-code ROM; zero where the ROM holds none.
  function automatic logic [7:0] scan_char(input logic [7:0] code);
    logic [7:0] c;
    case (code)
      8'd1:  c = 8'h1b;
      8'd2:  c = "1";
      8'd3:  c = "2";
      8'd4:  c = "3";
      8'd5:  c = "4";
      8'd6:  c = "5";
      8'd7:  c = "6";
      8'd8:  c = "7";
      8'd9:  c = "8";
      8'd10: c = "9";
      8'd11: c = "0";
      8'd12: c = "-";
      8'd13: c = "=";
      8'd14: c = 8'h7f;
      8'd15: c = 8'h09;
      8'd16: c = "Q";
      8'd17: c = "W";
      8'd18: c = "E";
      8'd19: c = "R";
      8'd20: c = "T";
      8'd21: c = "Y";
      8'd22: c = "U";
      8'd23: c = "I";
      8'd24: c = "O";
      8'd25: c = "P";
      8'd26: c = "[";
      8'd27: c = "]";
      8'd28: c = 8'h0a;
      8'd30: c = "A";
      8'd31: c = "S";
      8'd32: c = "D";
      8'd33: c = "F";
      8'd34: c = "G";
      8'd35: c = "H";
      8'd36: c = "J";
      8'd37: c = "K";
      8'd38: c = "L";
      8'd39: c = ";";
      8'd40: c = 8'h27;
      8'd43: c = 8'h5c;
      8'd44: c = "Z";
      8'd45: c = "X";
      8'd46: c = "C";
      8'd47: c = "V";
      8'd48: c = "B";
      8'd49: c = "N";
      8'd50: c = "M";
      8'd51: c = ",";
      8'd52: c = ".";
      8'd53: c = "/";
      8'd55: c = "*";
      8'd57: c = " ";
      8'd74: c = "-";
      8'd78: c = "+";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Function keys give the scan code in the high byte; others a character.
  function automatic logic [15:0] translate(input logic [7:0] code, input logic shift);
    logic [7:0] c;
    logic [15:0] r;
    c = scan_char(code);
    if (!shift) begin
      if (c >= "A" && c <= "Z") c = c + 8'h20;
    end else begin
      case (c)
        "1":   c = "!";
        "2":   c = "@";
        "3":   c = "#";
        "4":   c = "$";
        "5":   c = "%";
        "6":   c = "^";
        "7":   c = "&";
        "8":   c = "*";
        "9":   c = "(";
        "0":   c = ")";
        "-":   c = "_";
        "=":   c = "+";
        8'h5c: c = "|";
        ";":   c = ":";
        8'h27: c = 8'h22;
        ",":   c = "<";
        ".":   c = ">";
        "/":   c = "?";
        default: c = c;
      endcase
    end
    if ((code >= 8'h3b && code <= 8'h44) || code == 8'h57 || code == 8'h58) begin
      r = {code, 8'h00};
    end else begin
      r = {8'h00, c};
    end
    return r;
  endfunction

endpackage

### rtl/core/ievf_dp.sv
`timescale 1ns / 1ps
// Datapath: event memory, ring pointers, config registers and result register.
module ievf_dp import ievf_pkg::*; #(
  parameter int RING_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ievf_cmd_t             cmd,
  output ievf_sts_t             sts,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic                  cfg_data,
  input  logic [1:0]            action,
  input  logic [2:0]            event_kind,
  input  logic signed [15:0]    code_x,
  input  logic signed [15:0]    code_y,
  input  logic [2:0]            modifiers,
  input  logic                  res_ready,
  output logic                  res_valid,
  output logic                  valid_res,
  output logic [2:0]            out_kind,
  output logic signed [15:0]    out_code_x,
  output logic signed [15:0]    out_code_y,
  output logic [2:0]            out_modifiers,
  output logic                  dropped_oldest
);

  localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(RING_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  logic          enable;
  logic          ascii_mode;
  logic [PW-1:0] head;
  logic [PW-1:0] tail;
  slot_t         mem [RING_DEPTH];
  slot_t         rd_slot;
  slot_t         wr_slot;
  logic          r_hit;
  logic          r_push_ok;
  logic          r_drop;

  act_t          act;
  logic          push_ok;
  logic          drop;
  logic          hit;
  logic [PW-1:0] tail_bump;
  logic          is_key;
  logic [15:0]   x_out;

  assign act       = act_t'(action);
  assign tail_bump = bump(tail);
  assign push_ok   = (act == ACT_PUSH) && enable && (event_kind != KIND_NONE);
  assign drop      = push_ok && (tail_bump == head);
  assign hit       = ((act == ACT_POP) || (act == ACT_PEEK)) && enable && (head != tail);
  assign is_key    = (event_kind == KIND_KEY_DOWN) || (event_kind == KIND_KEY_UP);

  always_comb begin
    wr_slot.kind = event_kind;
    wr_slot.mods = modifiers;
    if (is_key) begin
      wr_slot.x = {8'h00, code_x[7:0]};
      wr_slot.y = '0;
    end else begin
      wr_slot.x = code_x;
      wr_slot.y = code_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b0;
      ascii_mode <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE: enable     <= cfg_data;
        CFG_ASCII:  ascii_mode <= cfg_data;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else if (cmd.take) begin
      case (act)
        ACT_PUSH: begin
          if (push_ok) tail <= tail_bump;
          // full ring: drop the oldest event
          if (drop) head <= bump(head);
        end
        ACT_POP: begin
          if (hit) head <= bump(head);
        end
        ACT_FLUSH: begin
          head <= '0;
          tail <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && push_ok) mem[tail] <= wr_slot;
    if (cmd.take) rd_slot <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      r_hit     <= hit;
      r_push_ok <= push_ok;
      r_drop    <= drop;
    end
  end

  assign x_out = (rd_slot.kind == KIND_KEY_DOWN && !ascii_mode)
               ? translate(rd_slot.x[7:0], rd_slot.mods[2]) : rd_slot.x;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      valid_res      <= r_hit || r_push_ok;
      dropped_oldest <= r_drop;
      out_kind       <= r_hit ? rd_slot.kind : KIND_NONE;
      out_code_x     <= r_hit ? x_out : '0;
      out_code_y     <= r_hit ? rd_slot.y : '0;
      out_modifiers  <= r_hit ? rd_slot.mods : '0;
    end
  end

  assign sts.out_free = !res_valid || res_ready;

endmodule

### rtl/core/ievf_ctrl.sv
`timescale 1ns / 1ps
// Controller: takes one request, then hands its result to the output register.
module ievf_ctrl import ievf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  ievf_sts_t sts,
  output logic      in_ready,
  output ievf_cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_FINISH;
      ST_FINISH: if (sts.out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_FINISH: begin
        // hold until the output register is free
        cmd.load = sts.out_free;
      end
      default: ;
    endcase
  end

endmodule

### rtl/core/input_event_fifo_with_key_translation.sv
`timescale 1ns / 1ps
// Input event ring with scan-code translation on read: top level.
//
// Requests enter on in_valid/in_ready: action selects push, pop, peek or
// flush, with the event fields alongside. Each request gives exactly one
// result on res_valid/res_ready. Configuration is a plain write port
// (cfg_we, cfg_index, cfg_data): index 0 enable, index 1 ascii_mode; write
// it only while no request is outstanding.
// Timing: a request is taken in the take step and its result is loaded into
// the output register in the finish step, once that register is free; res_valid
// rises with that load. One request is in flight at a time: no new request is
// taken until the finish step of the last one, set by the take/finish sequence
// of the controller and the registered read of the event memory.
// A result waiting in the output register does not stop the next request
// from being taken; a stalled receiver holds only the finish step.
// Reset empties the ring, clears enable and sets ascii_mode; the event memory
// itself is not cleared, since only written slots are ever read.
`include "input_event_fifo_with_key_translation_defines.svh"
module input_event_fifo_with_key_translation import ievf_pkg::*; #(
  parameter int RING_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic                  cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            action,
  input  logic [2:0]            event_kind,
  input  logic signed [15:0]    code_x,
  input  logic signed [15:0]    code_y,
  input  logic [2:0]            modifiers,
  output logic                  res_valid,
  input  logic                  res_ready,
  output logic                  valid_res,
  output logic [2:0]            out_kind,
  output logic signed [15:0]    out_code_x,
  output logic signed [15:0]    out_code_y,
  output logic [2:0]            out_modifiers,
  output logic                  dropped_oldest
);

  ievf_cmd_t cmd;
  ievf_sts_t sts;

  ievf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  ievf_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .action         (action),
    .event_kind     (event_kind),
    .code_x         (code_x),
    .code_y         (code_y),
    .modifiers      (modifiers),
    .res_ready      (res_ready),
    .res_valid      (res_valid),
    .valid_res      (valid_res),
    .out_kind       (out_kind),
    .out_code_x     (out_code_x),
    .out_code_y     (out_code_y),
    .out_modifiers  (out_modifiers),
    .dropped_oldest (dropped_oldest)
  );

  `IEVF_ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready)
  `IEVF_ASSERT_NOW(a_drop_is_push, clk, rst, res_valid && dropped_oldest,
                   valid_res && out_kind == KIND_NONE)
  `IEVF_ASSERT_NOW(a_kind_needs_hit, clk, rst, res_valid && out_kind != KIND_NONE, valid_res)
  `IEVF_ASSERT_NOW(a_none_is_zero, clk, rst, res_valid && !valid_res,
                   out_code_x == 16'sd0 && out_code_y == 16'sd0 && out_modifiers == 3'd0)

endmodule

### tb/tb_input_event_fifo_with_key_translation.sv
`timescale 1ns / 1ps
// Self-checking testbench for the input event ring with scan-code translation.
module tb_input_event_fifo_with_key_translation;
  import ievf_pkg::*;

  localparam int RING_DEPTH      = 64;
  localparam int PTR_W           = $clog2(RING_DEPTH);
  localparam int SCAN_TABLE_SIZE = 128;
  localparam int SHIFT_MOD       = 2;
  localparam int LONG_HOLD       = 400;
  localparam int IDLE_LIMIT      = 5000;
  localparam int SHOW_LIMIT      = 10;

  localparam logic [2:0] KIND_MOVE       = 3'd3;
  localparam logic [2:0] KIND_RIGHT_UP   = 3'd7;

  typedef struct packed {
    act_t        act;
    logic [2:0]  kind;
    logic [15:0] x;
    logic [15:0] y;
    logic [2:0]  mods;
  } ring_req_t;

  // Same field order as the result ports, so one compare covers them all.
  typedef struct packed {
    logic        ok;
    logic [2:0]  kind;
    logic [15:0] x;
    logic [15:0] y;
    logic [2:0]  mods;
    logic        dropped;
  } ring_res_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic                 cfg_data  = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [1:0]           action     = '0;
  logic [2:0]           event_kind = '0;
  logic signed [15:0]   code_x     = '0;
  logic signed [15:0]   code_y     = '0;
  logic [2:0]           modifiers  = '0;
  logic                 res_valid;
  logic                 res_ready = 1'b0;
  logic                 valid_res;
  logic [2:0]           out_kind;
  logic signed [15:0]   out_code_x;
  logic signed [15:0]   out_code_y;
  logic [2:0]           out_modifiers;
  logic                 dropped_oldest;

  // Predictor state
  slot_t            event_ring [RING_DEPTH];
  logic [PTR_W-1:0] head_ptr  = '0;
  logic [PTR_W-1:0] tail_ptr  = '0;
  logic             en_cfg    = 1'b0;
  logic             ascii_cfg = 1'b1;

  ring_req_t pending_reqs [$];
  ring_res_t expected_results [$];
  int        reqs_sent      = 0;
  int        reqs_taken     = 0;
  int        mismatch_count = 0;
  int        quiet_cycles   = 0;
  int        idle_pct       = 12;
  int        stalls_asked   = 0;
  int        stalls_served  = 0;
  int        hold_left      = 0;
  logic      req_taken      = 1'b0;

  input_event_fifo_with_key_translation #(.RING_DEPTH(RING_DEPTH)) dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .event_kind(event_kind), .code_x(code_x), .code_y(code_y),
    .modifiers(modifiers),
    .res_valid(res_valid), .res_ready(res_ready),
    .valid_res(valid_res), .out_kind(out_kind), .out_code_x(out_code_x),
    .out_code_y(out_code_y), .out_modifiers(out_modifiers),
    .dropped_oldest(dropped_oldest)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Set-1 scan code to character, with the shift layer applied.
  function automatic logic [15:0] key_to_char(input logic [7:0] code, input logic shift);
    string       num_row, q_row, a_row, z_row, plain, shifted;
    logic [15:0] c, orig;
    int          k;
    num_row = "1234567890-=";
    q_row   = "QWERTYUIOP[]";
    a_row   = "ASDFGHJKL;'";
    z_row   = "ZXCVBNM,./";
    plain   = "1234567890-=\\;',./";
    shifted = "!@#$%^&*()_+|:\"<>?";
    c = '0;
    if (int'(code) >= SCAN_TABLE_SIZE) begin
      c = '0;
    end else if ((code >= 8'h3b && code <= 8'h44) || code == 8'h57 || code == 8'h58) begin
      c = {code, 8'h00};
    end else if (code >= 2 && code <= 13) begin
      c = {8'h00, num_row[code - 2]};
    end else if (code >= 16 && code <= 27) begin
      c = {8'h00, q_row[code - 16]};
    end else if (code >= 30 && code <= 40) begin
      c = {8'h00, a_row[code - 30]};
    end else if (code >= 44 && code <= 53) begin
      c = {8'h00, z_row[code - 44]};
    end else begin
      case (code)
        8'd1:    c = 16'h001b;
        8'd14:   c = 16'h007f;
        8'd15:   c = 16'h0009;
        8'd28:   c = 16'h000a;
        8'd43:   c = 16'h005c;
        8'd55:   c = {8'h00, "*"};
        8'd57:   c = {8'h00, " "};
        8'd74:   c = {8'h00, "-"};
        8'd78:   c = {8'h00, "+"};
        default: c = '0;
      endcase
    end
    if (!shift) begin
      // lowercase letters
      if (c >= {8'h00, "A"} && c <= {8'h00, "Z"}) c = c + 16'h0020;
    end else begin
      orig = c;
      for (k = 0; k < plain.len(); k++) begin
        if (orig == {8'h00, plain[k]}) c = {8'h00, shifted[k]};
      end
    end
    return c;
  endfunction

  function automatic ring_res_t ring_step(input ring_req_t r);
    ring_res_t o;
    slot_t     s;
    o = '0;
    case (r.act)
      ACT_PUSH: begin
        if (en_cfg && r.kind != KIND_NONE) begin
          s.kind = r.kind;
          s.mods = r.mods;
          if (r.kind == KIND_KEY_DOWN || r.kind == KIND_KEY_UP) begin
            s.x = {8'h00, r.x[7:0]};
            s.y = '0;
          end else begin
            s.x = r.x;
            s.y = r.y;
          end
          event_ring[tail_ptr] = s;
          tail_ptr = next_ptr(tail_ptr);
          o.ok = 1'b1;
          // full: drop the oldest
          if (head_ptr == tail_ptr) begin
            head_ptr = next_ptr(head_ptr);
            o.dropped = 1'b1;
          end
        end
      end
      ACT_FLUSH: begin
        head_ptr = '0;
        tail_ptr = '0;
      end
      default: begin
        if (en_cfg && head_ptr != tail_ptr) begin
          s = event_ring[head_ptr];
          o.ok   = 1'b1;
          o.kind = s.kind;
          o.x    = s.x;
          o.y    = s.y;
          o.mods = s.mods;
          if (s.kind == KIND_KEY_DOWN && !ascii_cfg) o.x = key_to_char(s.x[7:0], s.mods[SHIFT_MOD]);
          if (r.act == ACT_POP) head_ptr = next_ptr(head_ptr);
        end
      end
    endcase
    return o;
  endfunction

  // Driver: advance to the next request once the current one is taken.
  always @(negedge clk) begin : driver
    ring_req_t nxt;
    if (!rst && (!in_valid || req_taken)) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
        nxt = pending_reqs.pop_front();
        in_valid   <= 1'b1;
        action     <= nxt.act;
        event_kind <= nxt.kind;
        code_x     <= nxt.x;
        code_y     <= nxt.y;
        modifiers  <= nxt.mods;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold whenever one is asked for.
  always @(negedge clk) begin : receiver
    if (rst) begin
      res_ready <= 1'b0;
    end else if (stalls_served != stalls_asked) begin
      stalls_served = stalls_asked;
      hold_left = LONG_HOLD;
      res_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin : monitor
    ring_req_t got_req;
    ring_res_t want;
    if (rst) begin
      req_taken <= 1'b0;
      quiet_cycles = 0;
    end else begin
      req_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        got_req.act  = act_t'(action);
        got_req.kind = event_kind;
        got_req.x    = code_x;
        got_req.y    = code_y;
        got_req.mods = modifiers;
        expected_results.push_back(ring_step(got_req));
        reqs_taken++;
      end
      if (res_valid && res_ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= SHOW_LIMIT)
            $display("%0t: result with no request outstanding", $time);
        end else begin
          want = expected_results.pop_front();
          if ({valid_res, out_kind, out_code_x, out_code_y, out_modifiers, dropped_oldest}
              !== want) begin
            mismatch_count++;
            if (mismatch_count <= SHOW_LIMIT) begin
              $display("%0t: expected ok=%0b kind=%0d x=%h y=%h mods=%0d drop=%0b", $time,
                       want.ok, want.kind, want.x, want.y, want.mods, want.dropped);
              $display("%0t:      got ok=%0b kind=%0d x=%h y=%h mods=%0d drop=%0b", $time,
                       valid_res, out_kind, out_code_x, out_code_y, out_modifiers,
                       dropped_oldest);
            end
          end
        end
      end
      if ((in_valid && in_ready) || (res_valid && res_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
          $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  task automatic queue_req(input act_t a, input logic [2:0] kind, input logic [15:0] x,
                           input logic [15:0] y, input logic [2:0] mods);
    ring_req_t r;
    r.act  = a;
    r.kind = kind;
    r.x    = x;
    r.y    = y;
    r.mods = mods;
    pending_reqs.push_back(r);
    reqs_sent++;
  endtask

  task automatic queue_random_push();
    logic [2:0]  kind;
    logic [15:0] x;
    int          pick;
    if ($urandom_range(19) == 0) kind = KIND_NONE;
    else if ($urandom_range(2) == 0) kind = KIND_KEY_DOWN;
    else kind = 3'($urandom_range(1, 7));
    pick = $urandom_range(9);
    if (kind == KIND_KEY_DOWN || kind == KIND_KEY_UP) begin
      if (pick < 6) x = 16'($urandom_range(0, 127));
      else if (pick < 8) x = 16'($urandom_range(128, 255));
      else x = 16'($urandom_range(16'hffff));
    end else begin
      x = 16'($urandom_range(16'hffff));
    end
    queue_req(ACT_PUSH, kind, x, 16'($urandom_range(16'hffff)), 3'($urandom_range(7)));
  endtask

  task automatic queue_random_read();
    act_t a;
    a = ($urandom_range(3) == 0) ? ACT_PEEK : ACT_POP;
    queue_req(a, 3'($urandom_range(7)), 16'($urandom_range(16'hffff)),
              16'($urandom_range(16'hffff)), 3'($urandom_range(7)));
  endtask

  // Bursts of pushes and of reads so the ring runs both full and empty.
  task automatic run_random(input int count);
    int left, len, mode, k;
    left = count;
    while (left > 0) begin
      mode = $urandom_range(9);
      len = $urandom_range(1, 80);
      if (len > left) len = left;
      for (k = 0; k < len; k++) begin
        if (mode < 4) queue_random_push();
        else if (mode < 7) queue_random_read();
        else if ($urandom_range(39) == 0)
          queue_req(ACT_FLUSH, 3'($urandom_range(7)), 16'($urandom_range(16'hffff)),
                    16'($urandom_range(16'hffff)), 3'($urandom_range(7)));
        else if ($urandom_range(1)) queue_random_push();
        else queue_random_read();
      end
      left -= len;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == CFG_ENABLE) en_cfg = val;
    else ascii_cfg = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold until every request is taken and answered, then let the block settle.
  task automatic drain();
    while (reqs_taken != reqs_sent || expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(input logic en, input logic ascii, input int count);
    write_reg(CFG_ENABLE, en);
    write_reg(CFG_ASCII, ascii);
    run_random(count);
    drain();
  endtask

  initial begin : stimulus
    int k;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Out of reset the block is disabled: everything returns none.
    queue_req(ACT_PUSH, KIND_KEY_DOWN, 16'h001e, 16'h0000, 3'd0);
    queue_req(ACT_POP, KIND_NONE, '0, '0, '0);
    queue_req(ACT_PEEK, KIND_NONE, '0, '0, '0);
    queue_req(ACT_FLUSH, KIND_NONE, '0, '0, '0);
    drain();

    // Raw codes: field extremes, key code masking, ignored kind none, empty reads.
    write_reg(CFG_ENABLE, 1'b1);
    queue_req(ACT_PUSH, KIND_KEY_DOWN, 16'hff1e, 16'h7fff, 3'd7);
    queue_req(ACT_PUSH, KIND_KEY_UP, 16'h7f80, 16'h8000, 3'd0);
    queue_req(ACT_PUSH, KIND_MOVE, 16'h8000, 16'h7fff, 3'd1);
    queue_req(ACT_PUSH, KIND_RIGHT_UP, 16'h7fff, 16'h8000, 3'd2);
    queue_req(ACT_PUSH, KIND_NONE, 16'hffff, 16'hffff, 3'd7);
    queue_req(ACT_PEEK, KIND_NONE, '0, '0, '0);
    for (k = 0; k < 5; k++) queue_req(ACT_POP, KIND_NONE, '0, '0, '0);
    drain();

    // Translation: function keys, case, shift layer, codes past the table.
    write_reg(CFG_ASCII, 1'b0);
    queue_req(ACT_PUSH, KIND_KEY_DOWN, 16'h003b, '0, 3'd4);
    queue_req(ACT_PUSH, KIND_KEY_DOWN, 16'h0058, '0, 3'd0);
    queue_req(ACT_PUSH, KIND_KEY_DOWN, 16'h001e, '0, 3'd0);
    queue_req(ACT_PUSH, KIND_KEY_DOWN, 16'h0028, '0, 3'd4);
    queue_req(ACT_PUSH, KIND_KEY_DOWN, 16'h0080, '0, 3'd0);
    queue_req(ACT_PUSH, KIND_KEY_DOWN, 16'h0059, '0, 3'd4);
    for (k = 0; k < 6; k++) queue_req(ACT_POP, KIND_NONE, '0, '0, '0);
    drain();

    run_phase(1'b1, 1'b0, 200);
    run_phase(1'b1, 1'b1, 180);
    run_phase(1'b0, 1'b0, 60);
    idle_pct = 0;
    run_phase(1'b1, 1'b0, 200);
    idle_pct = 12;

    // Back-pressure: hold the receiver while requests keep coming.
    write_reg(CFG_ENABLE, 1'b1);
    stalls_asked++;
    for (k = 0; k < 120; k++) begin
      if (k % 4 == 3) queue_random_read();
      else queue_random_push();
    end
    drain();

    run_phase(1'b0, 1'b1, 40);
    run_phase(1'b1, 1'b1, 200);
    run_phase(1'b1, 1'b0, 250);

    repeat (10) @(negedge clk);
    if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
